[design/clnw_pkg.sv]
package clnw_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned NibbleWidth = 4;
    localparam int unsigned ActionWidth = 2;
    localparam int unsigned SlotWidth = 4;

    localparam logic [ByteWidth-1:0] LeadByte = 8'd195;
    localparam logic [ByteWidth-1:0] Terminator = 8'd0;
    localparam logic [1:0] CgramBaseTop = 2'b01;

    localparam logic [ByteWidth-1:0] WrapPositionReset = 8'd17;
    localparam logic [ByteWidth-1:0] WrapCommandReset = 8'd192;

    typedef enum logic [ActionWidth-1:0] {
        ACT_TEXT  = 2'd0,
        ACT_INSTR = 2'd1,
        ACT_DATA  = 2'd2,
        ACT_SLOT  = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        CFG_WRAP_POSITION = 1'b0,
        CFG_WRAP_COMMAND  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_WRAP_HIGH = 2'd0,
        PH_WRAP_LOW  = 2'd1,
        PH_MAIN_HIGH = 2'd2,
        PH_MAIN_LOW  = 2'd3
    } phase_t;

    typedef struct packed {
        logic                 wrap_en;
        logic [ByteWidth-1:0] wrap_byte;
        logic                 main_en;
        logic [ByteWidth-1:0] main_byte;
        logic                 main_rs;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } glyph_t;

    function automatic glyph_t map_second(input logic [ByteWidth-1:0] b);
        glyph_t g;
        g.valid = 1'b1;
        unique case (b)
            8'd161:  g.code = 3'd0;
            8'd169:  g.code = 3'd1;
            8'd167:  g.code = 3'd2;
            8'd163:  g.code = 3'd3;
            8'd181:  g.code = 3'd4;
            default:
            begin
                g.valid = 1'b0;
                g.code  = 3'd0;
            end
        endcase
        return g;
    endfunction

endpackage

[design/char_lcd_nibble_writer_unit.sv]
// Character-LCD 4-bit writer.
// The input channel (in_valid/in_ready) takes one transaction per action:
// a text byte, an instruction byte, a raw data byte or a custom slot select.
// The output channel (out_valid/out_ready) gives one transaction per enable
// strobe: reg_select, a nibble, and last on the final strobe of an action.
// Each byte goes out high nibble first; a text byte at the wrap position is
// preceded by the wrap instruction, so one action makes zero to four strobes.
// The front end classifies an action in the cycle it is accepted and queues
// a job; it passes the queue and the job register to registered outputs.
// The back end emits one strobe per cycle while out_ready lets it, so
// throughput in actions is set by the strobe count of each action.
// The job queue holds QUEUE_DEPTH jobs; while the receiver stalls the queue
// fills and in_ready falls, and nothing is lost or repeated.
// Reset clears the character count, the lead-byte flag and the queue, and
// loads the wrap position 17 and the wrap instruction 192.
// Configuration writes are registered; they must be made while idle, which the block itself does not enforce.
module char_lcd_nibble_writer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [clnw_pkg::ByteWidth-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [clnw_pkg::ActionWidth-1:0]    action,
    input  logic [clnw_pkg::ByteWidth-1:0]      byte_value,
    input  logic [clnw_pkg::SlotWidth-1:0]      slot,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                reg_select,
    output logic [clnw_pkg::NibbleWidth-1:0]    nibble,
    output logic                                last
);

    logic           push_valid;
    logic           push_ready;
    clnw_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    clnw_pkg::job_t pop_job;

    clnw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .byte_value (byte_value),
        .slot       (slot),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    clnw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    clnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

endmodule

[design/clnw_front.sv]
module clnw_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [clnw_pkg::ByteWidth-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [clnw_pkg::ActionWidth-1:0]      action,
    input  logic [clnw_pkg::ByteWidth-1:0]        byte_value,
    input  logic [clnw_pkg::SlotWidth-1:0]        slot,
    input  logic                                  push_ready,
    output logic                                  push_valid,
    output clnw_pkg::job_t                        push_job
);

    logic [clnw_pkg::ByteWidth-1:0] wrap_position_reg;
    logic [clnw_pkg::ByteWidth-1:0] wrap_command_reg;
    logic [clnw_pkg::ByteWidth-1:0] char_count_reg;
    logic [clnw_pkg::ByteWidth-1:0] char_count_next;
    logic                           lead_pending_reg;
    logic                           lead_pending_next;
    logic                           accept;
    clnw_pkg::job_t                 job;
    clnw_pkg::glyph_t               glyph;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign glyph    = clnw_pkg::map_second(byte_value);

    always_comb
    begin
        job.wrap_en       = 1'b0;
        job.wrap_byte     = wrap_command_reg;
        job.main_en       = 1'b0;
        job.main_byte     = byte_value;
        job.main_rs       = 1'b1;
        char_count_next   = char_count_reg;
        lead_pending_next = lead_pending_reg;
        unique case (clnw_pkg::action_t'(action))
            clnw_pkg::ACT_TEXT:
            begin
                priority if (byte_value == clnw_pkg::Terminator)
                begin
                    char_count_next   = '0;
                    lead_pending_next = 1'b0;
                end
                else if (lead_pending_reg)
                begin
                    job.main_en       = glyph.valid;
                    job.main_byte     = {5'd0, glyph.code};
                    lead_pending_next = 1'b0;
                    char_count_next   = char_count_reg + 8'd1;
                end
                else
                begin
                    job.wrap_en = (char_count_reg == wrap_position_reg);
                    if (byte_value == clnw_pkg::LeadByte)
                    begin
                        lead_pending_next = 1'b1;
                    end
                    else
                    begin
                        job.main_en     = 1'b1;
                        char_count_next = char_count_reg + 8'd1;
                    end
                end
            end
            clnw_pkg::ACT_INSTR:
            begin
                job.main_en = 1'b1;
                job.main_rs = 1'b0;
            end
            clnw_pkg::ACT_DATA:
            begin
                job.main_en = 1'b1;
            end
            clnw_pkg::ACT_SLOT:
            begin
                job.main_en   = ~slot[3];
                job.main_rs   = 1'b0;
                job.main_byte = {clnw_pkg::CgramBaseTop, slot[2:0], 3'b000};
            end
            default:
            begin
                job.main_en = 1'b0;
            end
        endcase
    end

    assign push_valid = accept && (job.wrap_en || job.main_en);
    assign push_job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_position_reg <= clnw_pkg::WrapPositionReset;
            wrap_command_reg  <= clnw_pkg::WrapCommandReset;
            char_count_reg    <= '0;
            lead_pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (clnw_pkg::cfg_index_t'(cfg_index))
                    clnw_pkg::CFG_WRAP_POSITION: wrap_position_reg <= cfg_data;
                    clnw_pkg::CFG_WRAP_COMMAND:  wrap_command_reg  <= cfg_data;
                    default:                     wrap_command_reg  <= wrap_command_reg;
                endcase
            end
            if (accept)
            begin
                char_count_reg   <= char_count_next;
                lead_pending_reg <= lead_pending_next;
            end
        end
    end

endmodule

[design/clnw_fifo.sv]
module clnw_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  clnw_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output clnw_pkg::job_t pop_job
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CountWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [PtrWidth-1:0] PtrOne = PtrWidth'(1);
    localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);
    localparam logic [CountWidth-1:0] CountOne = CountWidth'(1);

    clnw_pkg::job_t          mem [DEPTH];
    logic [PtrWidth-1:0]     wr_ptr_reg;
    logic [PtrWidth-1:0]     rd_ptr_reg;
    logic [CountWidth-1:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = (count_reg != FullCount);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrOne;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrOne;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CountOne;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CountOne;
            end
        end
    end

endmodule

[design/clnw_back.sv]
module clnw_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  clnw_pkg::job_t                      pop_job,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                reg_select,
    output logic [clnw_pkg::NibbleWidth-1:0]    nibble,
    output logic                                last
);

    clnw_pkg::job_t                       job_reg;
    logic                                 job_valid_reg;
    clnw_pkg::phase_t                     phase_reg;
    clnw_pkg::phase_t                     phase_next;
    logic                                 out_valid_reg;
    logic                                 reg_select_reg;
    logic [clnw_pkg::NibbleWidth-1:0]     nibble_reg;
    logic                                 last_reg;
    logic                                 emit;
    logic                                 final_step;
    logic                                 on_main;
    logic [clnw_pkg::ByteWidth-1:0]       cur_byte;

    assign on_main    = phase_reg[1];
    assign cur_byte   = on_main ? job_reg.main_byte : job_reg.wrap_byte;
    assign final_step = (phase_reg == clnw_pkg::PH_MAIN_LOW)
                     || ((phase_reg == clnw_pkg::PH_WRAP_LOW) && !job_reg.main_en);
    assign emit       = job_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready  = !job_valid_reg || (emit && final_step);

    always_comb
    begin
        unique case (phase_reg)
            clnw_pkg::PH_WRAP_HIGH: phase_next = clnw_pkg::PH_WRAP_LOW;
            clnw_pkg::PH_WRAP_LOW:  phase_next = clnw_pkg::PH_MAIN_HIGH;
            clnw_pkg::PH_MAIN_HIGH: phase_next = clnw_pkg::PH_MAIN_LOW;
            default:                phase_next = clnw_pkg::PH_WRAP_HIGH;
        endcase
        if (pop_valid && pop_ready)
        begin
            phase_next = pop_job.wrap_en ? clnw_pkg::PH_WRAP_HIGH : clnw_pkg::PH_MAIN_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= clnw_pkg::PH_WRAP_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                job_valid_reg <= pop_valid;
            end
            if (emit || pop_ready)
            begin
                phase_reg <= phase_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            job_reg <= pop_job;
        end
        if (emit)
        begin
            reg_select_reg <= on_main ? job_reg.main_rs : 1'b0;
            nibble_reg     <= phase_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            last_reg       <= final_step;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = reg_select_reg;
    assign nibble     = nibble_reg;
    assign last       = last_reg;

endmodule
